@@ hdl/ppcs_pkg.sv @@
package ppcs_pkg;

	// operation codes carried in s_axis_tuser
	typedef enum logic [1:0] {
		OP_LOAD_FIRST  = 2'd0,
		OP_LOAD_SECOND = 2'd1,
		OP_EVALUATE    = 2'd2
	} op_t;

	// result status carried in m_axis_tuser
	typedef enum logic [1:0] {
		ST_CONSISTENT   = 2'd0,
		ST_SHARED       = 2'd1,
		ST_INCONSISTENT = 2'd2
	} status_t;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 16;

	localparam logic [CFG_IW-1:0] REG_EPSILON = 2'd0;
	localparam logic [CFG_IW-1:0] REG_GAIN    = 2'd1;

	localparam logic [CFG_DW-1:0] EPSILON_RST = 16'd3277;
	localparam logic [CFG_DW-1:0] GAIN_RST    = 16'd256;

	localparam int IN_DW    = 88;
	localparam int OUT_DW   = 16;
	localparam int IDX_W    = 8;
	localparam int NORMAL_W = 48;
	localparam int EXP_STEPS = 16;

	// exp(-2^(b-12)) in Q0.32
	localparam logic [31:0] EXP_ROM [EXP_STEPS] = '{
		32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
		32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
		32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
		32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
	};

endpackage

@@ hdl/ppcs_ram.sv @@
module ppcs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ hdl/plane_pair_consistency_scorer.sv @@
// Plane pair consistency scorer.
// Slave stream: s_axis_tuser carries the operation. Load items write one unit
// normal into the first- or second-scan store at point_slot; they give no
// result. Evaluate items name two associations and give exactly one result on
// the master stream: m_axis_tuser is the status, m_axis_tdata the Q0.16 score.
// Point indices wrap modulo MAX_POINTS. A normal loaded in one transfer is
// visible to an evaluate item in the very next transfer.
// An evaluate item passes pipeline stages s1..s24, then the output register.
// Throughput: one item per cycle while s_axis_tready is high; each of the
// 16 exponential stages holds one 32x32 multiply, which sets the clock rate.
// Config port: cfg_we/cfg_index/cfg_data, write only while no evaluate item
// is in flight. Index 0 is epsilon_limit, 1 is gaussian_gain, others ignored.
// Reset clears all valids and restores the register defaults; store contents
// are undefined until loaded.
// Stall: an output register plus a one-entry skid buffer. When the receiver
// stalls and the skid fills, s_axis_tready drops and the whole pipeline
// holds; nothing is lost or repeated.
module plane_pair_consistency_scorer #(
	parameter int MAX_POINTS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [7:0] point_slot, [23:8] normal_x, [39:24] normal_y, [55:40] normal_z,
	// [63:56] pair_i_in_first, [71:64] pair_i_in_second,
	// [79:72] pair_j_in_first, [87:80] pair_j_in_second
	input  logic [ppcs_pkg::IN_DW-1:0]    s_axis_tdata,
	// [1:0] operation
	input  logic [1:0]                    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [15:0] affinity
	output logic [ppcs_pkg::OUT_DW-1:0]   m_axis_tdata,
	// [1:0] pair_status
	output logic [1:0]                    m_axis_tuser,
	input  logic                          cfg_we,
	input  logic [ppcs_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [ppcs_pkg::CFG_DW-1:0]   cfg_data
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int NSTEP = ppcs_pkg::EXP_STEPS;

	// ---------------- configuration ----------------
	logic [15:0] eps_q;
	logic [15:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q  <= ppcs_pkg::EPSILON_RST;
			gain_q <= ppcs_pkg::GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppcs_pkg::REG_EPSILON: eps_q  <= cfg_data;
				ppcs_pkg::REG_GAIN:    gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- input decode ----------------
	logic adv;
	logic skid_vld_q;
	logic in_xfer;
	logic wr_first, wr_second, is_eval;

	assign adv           = !skid_vld_q;
	assign s_axis_tready = adv;
	assign in_xfer       = s_axis_tvalid && adv;

	always_comb begin
		wr_first  = 1'b0;
		wr_second = 1'b0;
		is_eval   = 1'b0;
		unique case (ppcs_pkg::op_t'(s_axis_tuser))
			ppcs_pkg::OP_LOAD_FIRST:  wr_first  = in_xfer;
			ppcs_pkg::OP_LOAD_SECOND: wr_second = in_xfer;
			ppcs_pkg::OP_EVALUATE:    is_eval   = in_xfer;
			default: ;
		endcase
	end

	// index wrap modulo MAX_POINTS as a constant table
	logic [AW-1:0] wrap_lut [256];

	for (genvar k = 0; k < 256; k++) begin : g_wrap
		assign wrap_lut[k] = AW'(k % MAX_POINTS);
	end

	logic [AW-1:0] slot_w, i1_w, i2_w, j1_w, j2_w;

	assign slot_w = wrap_lut[s_axis_tdata[7:0]];
	assign i1_w   = wrap_lut[s_axis_tdata[63:56]];
	assign i2_w   = wrap_lut[s_axis_tdata[71:64]];
	assign j1_w   = wrap_lut[s_axis_tdata[79:72]];
	assign j2_w   = wrap_lut[s_axis_tdata[87:80]];

	// ---------------- s1: normal stores (registered read) ----------------
	logic [ppcs_pkg::NORMAL_W-1:0] fa_s1, fb_s1, sa_s1, sb_s1;

	ppcs_ram #(.WIDTH(ppcs_pkg::NORMAL_W), .DEPTH(MAX_POINTS)) u_first (
		.clk     (clk),
		.we      (wr_first),
		.waddr   (slot_w),
		.wdata   (s_axis_tdata[55:8]),
		.re      (adv),
		.raddr_a (i1_w),
		.raddr_b (j1_w),
		.rdata_a (fa_s1),
		.rdata_b (fb_s1)
	);

	ppcs_ram #(.WIDTH(ppcs_pkg::NORMAL_W), .DEPTH(MAX_POINTS)) u_second (
		.clk     (clk),
		.we      (wr_second),
		.waddr   (slot_w),
		.wdata   (s_axis_tdata[55:8]),
		.re      (adv),
		.raddr_a (i2_w),
		.raddr_b (j2_w),
		.rdata_a (sa_s1),
		.rdata_b (sb_s1)
	);

	// ---------------- pipeline registers ----------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic shr_s1, shr_s2, shr_s3, shr_s4, shr_s5, shr_s6, shr_s7, shr_s8;

	logic signed [31:0] p1x_s2, p1y_s2, p1z_s2, p2x_s2, p2y_s2, p2z_s2;
	logic signed [33:0] sum1_s3, sum2_s3;
	logic signed [16:0] dot1_s4, dot2_s4;
	logic        [16:0] c_s5;
	logic               lt_s6, lt_s7;
	logic        [31:0] gp_s6;
	logic        [15:0] c16_s6;
	logic        [47:0] e_s7;
	logic        [15:0] x_s8;
	logic               kill_s8;

	function automatic logic signed [16:0] round_sat(input logic signed [33:0] s);
		logic signed [33:0] t;
		t = (s + 34'sd16384) >>> 15;
		if (t < -34'sd65536) begin
			return -17'sd65536;
		end else if (t > 34'sd65535) begin
			return 17'sd65535;
		end
		return t[16:0];
	endfunction

	logic signed [17:0] diff_w;
	logic        [47:0] es_w;

	assign diff_w = 18'(dot1_s4) - 18'(dot2_s4);
	assign es_w   = e_s7 + 48'd33554432;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= is_eval;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			shr_s1 <= (i1_w == j1_w) || (i2_w == j2_w);

			shr_s2 <= shr_s1;
			p1x_s2 <= $signed(fa_s1[15:0])  * $signed(fb_s1[15:0]);
			p1y_s2 <= $signed(fa_s1[31:16]) * $signed(fb_s1[31:16]);
			p1z_s2 <= $signed(fa_s1[47:32]) * $signed(fb_s1[47:32]);
			p2x_s2 <= $signed(sa_s1[15:0])  * $signed(sb_s1[15:0]);
			p2y_s2 <= $signed(sa_s1[31:16]) * $signed(sb_s1[31:16]);
			p2z_s2 <= $signed(sa_s1[47:32]) * $signed(sb_s1[47:32]);

			shr_s3  <= shr_s2;
			sum1_s3 <= 34'(p1x_s2) + 34'(p1y_s2) + 34'(p1z_s2);
			sum2_s3 <= 34'(p2x_s2) + 34'(p2y_s2) + 34'(p2z_s2);

			shr_s4  <= shr_s3;
			dot1_s4 <= round_sat(sum1_s3);
			dot2_s4 <= round_sat(sum2_s3);

			shr_s5 <= shr_s4;
			c_s5   <= diff_w[17] ? 17'(-diff_w) : diff_w[16:0];

			// c only reaches the kernel when below epsilon, so 16 bits suffice
			shr_s6 <= shr_s5;
			lt_s6  <= c_s5 < {1'b0, eps_q};
			gp_s6  <= 32'(gain_q) * 32'(c_s5[15:0]);
			c16_s6 <= c_s5[15:0];

			shr_s7 <= shr_s6;
			lt_s7  <= lt_s6;
			e_s7   <= 48'(gp_s6) * 48'(c16_s6);

			shr_s8  <= shr_s7;
			x_s8    <= es_w[41:26];
			kill_s8 <= !lt_s7 || (|es_w[47:42]);
		end
	end

	// ---------------- s9..s24: exponential, one x bit per stage ----------------
	// element k of each array is stage 9+k
	logic        vld_s9  [NSTEP];
	logic        shr_s9  [NSTEP];
	logic        kill_s9 [NSTEP];
	logic [15:0] x_s9    [NSTEP];
	logic [31:0] acc_s9  [NSTEP];
	logic        one_s9  [NSTEP];

	for (genvar k = 0; k < NSTEP; k++) begin : g_exp
		logic        v_in, shr_in, kill_in, one_in;
		logic [15:0] x_in;
		logic [31:0] acc_in;
		logic [63:0] prod;
		logic [31:0] acc_nxt;
		logic        one_nxt;

		if (k == 0) begin : g_head
			assign v_in    = vld_s8;
			assign shr_in  = shr_s8;
			assign kill_in = kill_s8;
			assign x_in    = x_s8;
			assign acc_in  = '0;
			assign one_in  = 1'b1;
		end else begin : g_link
			assign v_in    = vld_s9[k-1];
			assign shr_in  = shr_s9[k-1];
			assign kill_in = kill_s9[k-1];
			assign x_in    = x_s9[k-1];
			assign acc_in  = acc_s9[k-1];
			assign one_in  = one_s9[k-1];
		end

		assign prod = 64'(acc_in) * 64'(ppcs_pkg::EXP_ROM[k]) + 64'h8000_0000;

		// while the accumulator is still exactly 1.0 the product is the constant
		always_comb begin
			acc_nxt = acc_in;
			one_nxt = one_in;
			if (x_in[k]) begin
				one_nxt = 1'b0;
				acc_nxt = one_in ? ppcs_pkg::EXP_ROM[k] : prod[63:32];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s9[k] <= 1'b0;
			end else if (adv) begin
				vld_s9[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				shr_s9[k]  <= shr_in;
				kill_s9[k] <= kill_in;
				x_s9[k]    <= x_in;
				acc_s9[k]  <= acc_nxt;
				one_s9[k]  <= one_nxt;
			end
		end
	end

	// ---------------- result formatting ----------------
	logic                  fin_vld;
	logic [32:0]           rnd_w;
	logic [15:0]           score_w;
	ppcs_pkg::status_t     fin_status;
	logic [15:0]           fin_aff;

	assign fin_vld = vld_s9[NSTEP-1];
	assign rnd_w   = {1'b0, acc_s9[NSTEP-1]} + 33'h0_0000_8000;

	always_comb begin
		if (one_s9[NSTEP-1] || rnd_w[32]) begin
			score_w = 16'hFFFF;
		end else begin
			score_w = rnd_w[31:16];
		end
	end

	always_comb begin
		fin_aff = '0;
		priority if (shr_s9[NSTEP-1]) begin
			fin_status = ppcs_pkg::ST_SHARED;
		end else if (kill_s9[NSTEP-1] || score_w == '0) begin
			fin_status = ppcs_pkg::ST_INCONSISTENT;
		end else begin
			fin_status = ppcs_pkg::ST_CONSISTENT;
			fin_aff    = score_w;
		end
	end

	// ---------------- output register and skid buffer ----------------
	logic                  out_vld_q;
	ppcs_pkg::status_t     out_status_q, skid_status_q;
	logic [15:0]           out_aff_q, skid_aff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_axis_tready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (!out_vld_q || m_axis_tready) begin
			out_vld_q <= fin_vld;
		end else if (fin_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_axis_tready) begin
				out_status_q <= skid_status_q;
				out_aff_q    <= skid_aff_q;
			end
		end else if (!out_vld_q || m_axis_tready) begin
			out_status_q <= fin_status;
			out_aff_q    <= fin_aff;
		end else begin
			skid_status_q <= fin_status;
			skid_aff_q    <= fin_aff;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_aff_q;
	assign m_axis_tuser  = out_status_q;

	// ---------------- assertions ----------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid buffer holds a transfer while the output is empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !m_axis_tready |=> skid_vld_q && !s_axis_tready)
		else $error("skid buffer drained or input opened during a stall");

	a_score_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ((out_status_q == ppcs_pkg::ST_CONSISTENT) == (out_aff_q != '0)))
		else $error("affinity and status disagree");

endmodule
